/* hw/rtl/pbrq_pkg.sv */
// ============================================================================
// pbrq_pkg: shared types and codes of the priority bitmap ready queue
// Operation and status codes, sequencer states and memory write-enable groups.
// ============================================================================
package pbrq_pkg;

    // Width of one leaf group of the level bitmap search
    localparam int GROUP = 16;

    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_SCHED = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_QUEUED     = 2'd1,
        ST_NOT_QUEUED = 2'd2,
        ST_NO_RUN     = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH0,
        S_PUSH1,
        S_PUSH2,
        S_UL1,
        S_UL2,
        S_UL3,
        S_PK1,
        S_PK2,
        S_PK3,
        S_SW,
        S_SWP,
        S_TK1,
        S_TKL,
        S_OUT
    } t_state;

    // Field write enables of the per-thread memory
    typedef struct packed {
        logic level;
        logic rr;
        logic sl;
        logic slen;
        logic fwd;
        logic bwd;
    } t_tm_we;

    // Field write enables of the per-level memory
    typedef struct packed {
        logic head;
        logic tail;
    } t_lm_we;

endpackage

/* hw/rtl/pbrq_thread_mem.sv */
// ============================================================================
// pbrq_thread_mem: per-thread record memory
// One port, registered read, field write enables.
// ============================================================================
module pbrq_thread_mem #(
    parameter int THREADS    = 64,
    parameter int LEVELS     = 256,
    parameter int SLICE_BITS = 16
) (
    input  logic                       i_clk,
    input  logic [$clog2(THREADS)-1:0] i_addr,
    input  logic                       i_rd,
    input  pbrq_pkg::t_tm_we           i_we,
    input  logic [$clog2(LEVELS)-1:0]  i_level,
    input  logic                       i_rr,
    input  logic [SLICE_BITS-1:0]      i_sl,
    input  logic [SLICE_BITS-1:0]      i_slen,
    input  logic [$clog2(THREADS)-1:0] i_fwd,
    input  logic [$clog2(THREADS)-1:0] i_bwd,
    output logic [$clog2(LEVELS)-1:0]  o_level,
    output logic                       o_rr,
    output logic [SLICE_BITS-1:0]      o_sl,
    output logic [SLICE_BITS-1:0]      o_slen,
    output logic [$clog2(THREADS)-1:0] o_fwd,
    output logic [$clog2(THREADS)-1:0] o_bwd
);
    localparam int TW = $clog2(THREADS);
    localparam int LW = $clog2(LEVELS);

    logic [LW-1:0]         m_level [THREADS];
    logic                  m_rr    [THREADS];
    logic [SLICE_BITS-1:0] m_sl    [THREADS];
    logic [SLICE_BITS-1:0] m_slen  [THREADS];
    logic [TW-1:0]         m_fwd   [THREADS];
    logic [TW-1:0]         m_bwd   [THREADS];

    always_ff @(posedge i_clk) begin
        if (i_we.level) m_level[i_addr] <= i_level;
        if (i_we.rr)    m_rr[i_addr]    <= i_rr;
        if (i_we.sl)    m_sl[i_addr]    <= i_sl;
        if (i_we.slen)  m_slen[i_addr]  <= i_slen;
        if (i_we.fwd)   m_fwd[i_addr]   <= i_fwd;
        if (i_we.bwd)   m_bwd[i_addr]   <= i_bwd;
        if (i_rd) begin
            o_level <= m_level[i_addr];
            o_rr    <= m_rr[i_addr];
            o_sl    <= m_sl[i_addr];
            o_slen  <= m_slen[i_addr];
            o_fwd   <= m_fwd[i_addr];
            o_bwd   <= m_bwd[i_addr];
        end
    end
endmodule

/* hw/rtl/pbrq_level_mem.sv */
// ============================================================================
// pbrq_level_mem: per-level head and tail memory
// One port, registered read, head and tail written separately.
// ============================================================================
module pbrq_level_mem #(
    parameter int THREADS = 64,
    parameter int LEVELS  = 256
) (
    input  logic                       i_clk,
    input  logic [$clog2(LEVELS)-1:0]  i_addr,
    input  logic                       i_rd,
    input  pbrq_pkg::t_lm_we           i_we,
    input  logic [$clog2(THREADS)-1:0] i_head,
    input  logic [$clog2(THREADS)-1:0] i_tail,
    output logic [$clog2(THREADS)-1:0] o_head,
    output logic [$clog2(THREADS)-1:0] o_tail
);
    localparam int TW = $clog2(THREADS);

    logic [TW-1:0] m_head [LEVELS];
    logic [TW-1:0] m_tail [LEVELS];

    always_ff @(posedge i_clk) begin
        if (i_we.head) m_head[i_addr] <= i_head;
        if (i_we.tail) m_tail[i_addr] <= i_tail;
        if (i_rd) begin
            o_head <= m_head[i_addr];
            o_tail <= m_tail[i_addr];
        end
    end
endmodule

/* hw/rtl/pbrq_bitmap.sv */
// ============================================================================
// pbrq_bitmap: non-empty level bitmap with two-stage highest-level search
// Group summary encode, then encode inside the winning group.
// ============================================================================
module pbrq_bitmap #(
    parameter int LEVELS = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_set,
    input  logic                      i_clr,
    input  logic [$clog2(LEVELS)-1:0] i_lvl,
    output logic                      o_bit,
    output logic                      o_any,
    output logic [$clog2(LEVELS)-1:0] o_lvl
);
    localparam int LW  = $clog2(LEVELS);
    localparam int G   = pbrq_pkg::GROUP;
    localparam int NG  = (LEVELS + G - 1) / G;
    localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
    localparam int PAD = NG * G;
    localparam int EW  = $clog2(G);

    logic [LEVELS-1:0] r_bits;
    logic [PAD-1:0]    w_pad;
    logic [NG-1:0]     w_sum;
    logic [GW-1:0]     w_gsel;
    logic [GW-1:0]     r_grp;
    logic              r_any1;
    logic [G-1:0]      w_win;
    logic [EW-1:0]     w_isel;

    assign w_pad = PAD'(r_bits);
    assign o_bit = r_bits[i_lvl];

    always_comb begin
        w_gsel = '0;
        for (int g = 0; g < NG; g++) begin
            w_sum[g] = |w_pad[g*G +: G];
            if (w_sum[g]) w_gsel = GW'(g);
        end
    end

    assign w_win = w_pad[32'(r_grp)*G +: G];

    always_comb begin
        w_isel = '0;
        for (int i = 0; i < G; i++) begin
            if (w_win[i]) w_isel = EW'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
        end else begin
            if (i_set) r_bits[i_lvl] <= 1'b1;
            if (i_clr) r_bits[i_lvl] <= 1'b0;
        end
        r_grp  <= w_gsel;
        r_any1 <= |w_sum;
        o_any  <= r_any1;
        o_lvl  <= LW'(32'(r_grp)*G + 32'(w_isel));
    end
endmodule

/* hw/rtl/priority_bitmap_ready_queue_core.sv */
// ============================================================================
// priority_bitmap_ready_queue_core: hardware ready queue, priority levels
// One FIFO list per level, bitmap of non-empty levels, list state in memories.
// ============================================================================
//
//  channel   dir  handshake                        payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tuser op, tdata thread fields
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata result fields
//  cfg       in   i_cfg_we                         i_cfg_wdata idle thread
//
// One operation at a time; the length of a beat is set by the single port of
// the thread memory (list links and records are read and written one access a
// cycle) and by the registered bitmap search. A rejected enqueue or dequeue
// and a tick with nothing running are the shortest, and a schedule that
// unlinks and puts back the previous thread takes the most.
// Reset is synchronous, active low; it empties all levels at once (bitmap
// flops), so no clearing pass is needed. A result waits in the output register
// while the next beat is accepted; the sequencer stalls only when a second
// result is ready before the first is taken.
// ============================================================================
module priority_bitmap_ready_queue_core #(
    parameter int THREADS    = 64,
    parameter int LEVELS     = 256,
    parameter int SLICE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: thread_id[5:0], priority_req[13:6], round_robin[14], slice_reload[30:15]
    input  logic [31:0] i_s_axis_tdata,
    // tuser: op[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: selected_thread[5:0], switched[6], resched_req[7], ready_count[14:8],
    //        status[16:15]
    output logic [23:0] o_m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata
);
    localparam int TW = $clog2(THREADS);
    localparam int LW = $clog2(LEVELS);
    localparam int CW = $clog2(THREADS + 1);
    localparam int SB = SLICE_BITS;

    // Reduce a 6-bit thread number modulo THREADS by a constant lookup
    function automatic logic [TW-1:0] f_mod(input logic [5:0] x);
        logic [TW-1:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) begin
            if (x == 6'(i)) r = TW'(i % THREADS);
        end
        return r;
    endfunction

    pbrq_pkg::t_state r_state, n_state;

    // Beat fields
    pbrq_pkg::t_op     r_op;
    logic [TW-1:0]     r_t;
    logic [7:0]        r_prio;
    logic              r_rr;
    logic [SB-1:0]     r_reload;

    // Scheduler state
    logic [THREADS-1:0] r_inq, n_inq;
    logic [THREADS-1:0] r_wr, n_wr;
    logic [TW-1:0]      r_run, n_run;
    logic               r_rv, n_rv;
    logic [CW-1:0]      r_total, n_total;
    logic               r_resched, n_resched;
    logic [5:0]         r_idle;

    // Working registers
    logic [TW-1:0]         r_x, n_x;
    logic [LW-1:0]         r_lvl, n_lvl;
    logic [TW-1:0]         r_fwd, n_fwd;
    logic [TW-1:0]         r_bwd, n_bwd;
    logic [TW-1:0]         r_tail, n_tail;
    logic                  r_is_tail, n_is_tail;
    logic [TW-1:0]         r_next, n_next;
    logic [LW-1:0]         r_clvl, n_clvl;
    pbrq_pkg::t_status     r_status, n_status;
    logic                  r_switched, n_switched;

    // Output register
    logic        r_mv, n_mv;
    logic [23:0] r_mdata, n_mdata;

    // Memory ports
    logic [TW-1:0]     tm_addr;
    logic              tm_rd;
    pbrq_pkg::t_tm_we  tm_we;
    logic [LW-1:0]     tm_wlevel, tm_qlevel;
    logic              tm_wrr, tm_qrr;
    logic [SB-1:0]     tm_wsl, tm_qsl, tm_wslen, tm_qslen;
    logic [TW-1:0]     tm_wfwd, tm_qfwd, tm_wbwd, tm_qbwd;
    logic [LW-1:0]     lm_addr;
    logic              lm_rd;
    pbrq_pkg::t_lm_we  lm_we;
    logic [TW-1:0]     lm_whead, lm_wtail, lm_qhead, lm_qtail;
    logic              bm_set, bm_clr, bm_bit, bm_any;
    logic [LW-1:0]     bm_idx, bm_lvl;

    // Helpers
    logic              w_accept;
    logic [TW-1:0]     w_maddr;
    logic              w_valid_rec;
    logic [LW-1:0]     q_level;
    logic              q_rr;
    logic [SB-1:0]     q_sl, q_slen, w_dec;
    logic [LW-1:0]     w_sat;
    logic [TW-1:0]     w_pick;
    logic              w_is_head, w_is_tail, w_sw, w_push_prev, w_free;
    logic [31:0]       w_reload32;
    pbrq_pkg::t_state  w_after_ul, w_after_pick;

    pbrq_thread_mem #(.THREADS(THREADS), .LEVELS(LEVELS), .SLICE_BITS(SB)) u_tm (
        .i_clk(i_clk), .i_addr(tm_addr), .i_rd(tm_rd), .i_we(tm_we),
        .i_level(tm_wlevel), .i_rr(tm_wrr), .i_sl(tm_wsl), .i_slen(tm_wslen),
        .i_fwd(tm_wfwd), .i_bwd(tm_wbwd),
        .o_level(tm_qlevel), .o_rr(tm_qrr), .o_sl(tm_qsl), .o_slen(tm_qslen),
        .o_fwd(tm_qfwd), .o_bwd(tm_qbwd)
    );

    pbrq_level_mem #(.THREADS(THREADS), .LEVELS(LEVELS)) u_lm (
        .i_clk(i_clk), .i_addr(lm_addr), .i_rd(lm_rd), .i_we(lm_we),
        .i_head(lm_whead), .i_tail(lm_wtail), .o_head(lm_qhead), .o_tail(lm_qtail)
    );

    pbrq_bitmap #(.LEVELS(LEVELS)) u_bm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_set(bm_set), .i_clr(bm_clr),
        .i_lvl(bm_idx), .o_bit(bm_bit), .o_any(bm_any), .o_lvl(bm_lvl)
    );

    assign o_s_axis_tready = (r_state == pbrq_pkg::S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_mv;
    assign o_m_axis_tdata  = r_mdata;
    assign w_free          = !r_mv || i_m_axis_tready;

    // A record never written reads as all zero (masked by the written flags)
    always_comb begin
        priority case (r_state)
            pbrq_pkg::S_TK1: w_maddr = r_run;
            pbrq_pkg::S_TKL: w_maddr = r_next;
            default:         w_maddr = r_x;
        endcase
    end
    assign w_valid_rec = r_wr[w_maddr];
    assign q_level = w_valid_rec ? tm_qlevel : '0;
    assign q_rr    = w_valid_rec ? tm_qrr    : 1'b0;
    assign q_sl    = w_valid_rec ? tm_qsl    : '0;
    assign q_slen  = w_valid_rec ? tm_qslen  : '0;
    assign w_dec   = q_sl - SB'(1);

    assign w_sat = ({1'b0, r_prio} >= 9'(LEVELS)) ? LW'(LEVELS - 1) : LW'(r_prio);
    assign w_pick = (r_state == pbrq_pkg::S_PK3) ? lm_qhead : f_mod(r_idle);
    assign w_is_head = (lm_qhead == r_x);
    assign w_is_tail = (lm_qtail == r_x);
    assign w_sw = !(r_rv && (r_run == r_next));
    assign w_push_prev = r_rv && !r_inq[r_run];
    assign w_reload32 = {16'b0, i_s_axis_tdata[30:15]};

    assign w_after_ul = (r_op == pbrq_pkg::OP_SCHED) ? pbrq_pkg::S_SW : pbrq_pkg::S_OUT;
    assign w_after_pick = (r_op == pbrq_pkg::OP_TICK) ? pbrq_pkg::S_TKL :
                          (r_inq[w_pick] ? pbrq_pkg::S_UL1 : pbrq_pkg::S_SW);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pbrq_pkg::S_IDLE:   if (w_accept) n_state = pbrq_pkg::S_DECODE;
            pbrq_pkg::S_DECODE: begin
                unique case (r_op)
                    pbrq_pkg::OP_ENQ:
                        n_state = r_inq[r_t] ? pbrq_pkg::S_OUT : pbrq_pkg::S_PUSH0;
                    pbrq_pkg::OP_DEQ:
                        n_state = r_inq[r_t] ? pbrq_pkg::S_UL1 : pbrq_pkg::S_OUT;
                    pbrq_pkg::OP_SCHED: n_state = pbrq_pkg::S_PK1;
                    pbrq_pkg::OP_TICK:
                        n_state = r_rv ? pbrq_pkg::S_TK1 : pbrq_pkg::S_OUT;
                endcase
            end
            pbrq_pkg::S_PUSH0: n_state = bm_bit ? pbrq_pkg::S_PUSH1 : pbrq_pkg::S_OUT;
            pbrq_pkg::S_PUSH1: n_state = pbrq_pkg::S_PUSH2;
            pbrq_pkg::S_PUSH2: n_state = pbrq_pkg::S_OUT;
            pbrq_pkg::S_UL1:   n_state = pbrq_pkg::S_UL2;
            pbrq_pkg::S_UL2:   n_state = (w_is_head && w_is_tail) ? w_after_ul
                                                                   : pbrq_pkg::S_UL3;
            pbrq_pkg::S_UL3:   n_state = w_after_ul;
            pbrq_pkg::S_PK1:   n_state = pbrq_pkg::S_PK2;
            pbrq_pkg::S_PK2:   n_state = bm_any ? pbrq_pkg::S_PK3 : w_after_pick;
            pbrq_pkg::S_PK3:   n_state = w_after_pick;
            pbrq_pkg::S_SW:    n_state = (w_sw && w_push_prev) ? pbrq_pkg::S_SWP
                                                                : pbrq_pkg::S_OUT;
            pbrq_pkg::S_SWP:   n_state = pbrq_pkg::S_PUSH0;
            pbrq_pkg::S_TK1:
                n_state = (q_rr && (q_sl != '0) && (w_dec == '0)) ? pbrq_pkg::S_OUT
                                                                   : pbrq_pkg::S_PK1;
            pbrq_pkg::S_TKL:   n_state = pbrq_pkg::S_OUT;
            pbrq_pkg::S_OUT:   if (w_free) n_state = pbrq_pkg::S_IDLE;
            default:           n_state = pbrq_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_inq = r_inq;   n_wr = r_wr;       n_run = r_run;     n_rv = r_rv;
        n_total = r_total; n_resched = r_resched;
        n_x = r_x;       n_lvl = r_lvl;     n_fwd = r_fwd;     n_bwd = r_bwd;
        n_tail = r_tail; n_is_tail = r_is_tail; n_next = r_next; n_clvl = r_clvl;
        n_status = r_status; n_switched = r_switched;
        n_mv = r_mv && !i_m_axis_tready;
        n_mdata = r_mdata;
        tm_addr = r_x;   tm_rd = 1'b0;      tm_we = '0;
        tm_wlevel = w_sat; tm_wrr = r_rr;   tm_wsl = r_reload; tm_wslen = r_reload;
        tm_wfwd = r_x;   tm_wbwd = r_tail;
        lm_addr = r_lvl; lm_rd = 1'b0;      lm_we = '0;
        lm_whead = r_x;  lm_wtail = r_x;
        bm_set = 1'b0;   bm_clr = 1'b0;     bm_idx = r_lvl;

        unique case (r_state)
            pbrq_pkg::S_IDLE: begin
                n_status   = pbrq_pkg::ST_OK;
                n_switched = 1'b0;
            end
            pbrq_pkg::S_DECODE: begin
                unique case (r_op)
                    pbrq_pkg::OP_ENQ: begin
                        if (r_inq[r_t]) begin
                            n_status = pbrq_pkg::ST_QUEUED;
                        end else begin
                            tm_addr = r_t;
                            tm_we.level = 1'b1; tm_we.rr = 1'b1;
                            tm_we.sl = 1'b1;    tm_we.slen = 1'b1;
                            n_wr[r_t] = 1'b1;
                            n_x   = r_t;
                            n_lvl = w_sat;
                        end
                    end
                    pbrq_pkg::OP_DEQ: begin
                        if (!r_inq[r_t]) begin
                            n_status = pbrq_pkg::ST_NOT_QUEUED;
                        end else begin
                            tm_addr = r_t;
                            tm_rd   = 1'b1;
                            n_x     = r_t;
                        end
                    end
                    pbrq_pkg::OP_SCHED: n_resched = 1'b0;
                    pbrq_pkg::OP_TICK: begin
                        if (!r_rv) begin
                            n_status = pbrq_pkg::ST_NO_RUN;
                        end else begin
                            tm_addr = r_run;
                            tm_rd   = 1'b1;
                        end
                    end
                endcase
            end
            pbrq_pkg::S_PUSH0: begin
                if (bm_bit) begin
                    lm_rd = 1'b1;
                end else begin
                    lm_we    = '{head: 1'b1, tail: 1'b1};
                    bm_set   = 1'b1;
                    n_inq[r_x] = 1'b1;
                    n_total  = r_total + CW'(1);
                end
            end
            pbrq_pkg::S_PUSH1: begin
                // link the old tail forward to the new thread, move the tail
                n_tail    = lm_qtail;
                tm_addr   = lm_qtail;
                tm_we.fwd = 1'b1;
                lm_we.tail = 1'b1;
            end
            pbrq_pkg::S_PUSH2: begin
                tm_we.bwd  = 1'b1;
                n_inq[r_x] = 1'b1;
                n_total    = r_total + CW'(1);
            end
            pbrq_pkg::S_UL1: begin
                n_lvl   = q_level;
                n_fwd   = tm_qfwd;
                n_bwd   = tm_qbwd;
                lm_addr = q_level;
                lm_rd   = 1'b1;
            end
            pbrq_pkg::S_UL2: begin
                n_is_tail  = w_is_tail;
                n_inq[r_x] = 1'b0;
                if (r_total != '0) n_total = r_total - CW'(1);
                if (w_is_head && w_is_tail) begin
                    bm_clr = 1'b1;
                end else begin
                    lm_whead   = r_fwd;
                    lm_wtail   = r_bwd;
                    lm_we.head = w_is_head;
                    lm_we.tail = w_is_tail;
                    if (!w_is_head) begin
                        tm_addr   = r_bwd;
                        tm_wfwd   = r_fwd;
                        tm_we.fwd = 1'b1;
                    end
                end
            end
            pbrq_pkg::S_UL3: begin
                if (!r_is_tail) begin
                    tm_addr   = r_fwd;
                    tm_wbwd   = r_bwd;
                    tm_we.bwd = 1'b1;
                end
            end
            pbrq_pkg::S_PK1: ;
            pbrq_pkg::S_PK2, pbrq_pkg::S_PK3: begin
                if ((r_state == pbrq_pkg::S_PK2) && bm_any) begin
                    lm_addr = bm_lvl;
                    lm_rd   = 1'b1;
                end else begin
                    n_next  = w_pick;
                    tm_addr = w_pick;
                    if (r_op == pbrq_pkg::OP_TICK) begin
                        tm_rd = 1'b1;
                    end else if (r_inq[w_pick]) begin
                        tm_rd = 1'b1;
                        n_x   = w_pick;
                    end
                end
            end
            pbrq_pkg::S_SW: begin
                if (w_sw) begin
                    n_run      = r_next;
                    n_rv       = 1'b1;
                    n_switched = 1'b1;
                    if (w_push_prev) begin
                        n_x     = r_run;
                        tm_addr = r_run;
                        tm_rd   = 1'b1;
                    end
                end
            end
            pbrq_pkg::S_SWP: n_lvl = q_level;
            pbrq_pkg::S_TK1: begin
                n_clvl  = q_level;
                tm_addr = r_run;
                if (q_rr && (q_sl != '0)) begin
                    tm_we.sl = 1'b1;
                    if (w_dec == '0) begin
                        // slice ran out: reload and request a reschedule
                        tm_wsl    = q_slen;
                        n_resched = 1'b1;
                    end else begin
                        tm_wsl = w_dec;
                    end
                end
            end
            pbrq_pkg::S_TKL: begin
                if ((r_next != r_run) && (q_level > r_clvl)) n_resched = 1'b1;
            end
            pbrq_pkg::S_OUT: begin
                if (w_free) begin
                    n_mv    = 1'b1;
                    n_mdata = {7'b0, r_status, 7'(32'(r_total)), r_resched, r_switched,
                               6'(32'(r_run))};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pbrq_pkg::S_IDLE;
            r_inq     <= '0;
            r_wr      <= '0;
            r_run     <= '0;
            r_rv      <= 1'b0;
            r_total   <= '0;
            r_resched <= 1'b0;
            r_idle    <= '0;
            r_mv      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_inq     <= n_inq;
            r_wr      <= n_wr;
            r_run     <= n_run;
            r_rv      <= n_rv;
            r_total   <= n_total;
            r_resched <= n_resched;
            r_mv      <= n_mv;
            if (i_cfg_we) r_idle <= i_cfg_wdata;
        end
        if (w_accept) begin
            r_op     <= pbrq_pkg::t_op'(i_s_axis_tuser);
            r_t      <= f_mod(i_s_axis_tdata[5:0]);
            r_prio   <= i_s_axis_tdata[13:6];
            r_rr     <= i_s_axis_tdata[14];
            r_reload <= w_reload32[SB-1:0];
        end
        r_x        <= n_x;
        r_lvl      <= n_lvl;
        r_fwd      <= n_fwd;
        r_bwd      <= n_bwd;
        r_tail     <= n_tail;
        r_is_tail  <= n_is_tail;
        r_next     <= n_next;
        r_clvl     <= n_clvl;
        r_status   <= n_status;
        r_switched <= n_switched;
        r_mdata    <= n_mdata;
    end

    // Count never exceeds the thread population
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_total) <= THREADS)
        else $error("ready count overflow");

    // An accepted beat always starts the sequencer
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == pbrq_pkg::S_DECODE))
        else $error("accepted beat not decoded");

    // A waiting result is held until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mv && !i_m_axis_tready) |=> (r_mv && $stable(r_mdata)))
        else $error("result dropped while stalled");

    // The running flag never falls once set
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rv |=> r_rv)
        else $error("running thread lost");
endmodule
